// ===== hw/rtl/wfps_pkg.sv =====
// Shared types and constants for the water-filling path splitter
`default_nettype none
package wfps_pkg;
    localparam int NumPaths = 4;
    localparam int IdxW = $clog2(NumPaths);
    localparam int CntW = $clog2(NumPaths + 1);
    localparam int DataW = 32;
    localparam logic [2:0] PathCountReset = 3'd4;
    localparam logic [1:0] AddrPathCount = 2'd0;
    // ceil(2^33 / 3): exact quotient by three for any 32-bit numerator
    localparam logic [DataW-1:0] DivThreeRecip = 32'hAAAA_AAAB;

    typedef logic signed [DataW-1:0] t_bal;
    typedef logic [DataW-1:0] t_word;

    typedef struct packed {
        logic        fill;
        logic [CntW-1:0] active;
        logic [DataW:0]  each;
        logic [CntW-1:0] extra;
    } t_round;
endpackage
`default_nettype wire

// ===== hw/rtl/wfps_lane.sv =====
// One path lane: rank position and share accumulator
`default_nettype none
module wfps_lane (
    input  wire logic              i_clk,
    input  wire logic              i_clear,
    input  wire wfps_pkg::t_round  i_round,
    input  wire logic [wfps_pkg::CntW-1:0] i_rank,
    output logic [wfps_pkg::DataW-1:0]     o_share
);
    import wfps_pkg::*;
    logic [DataW-1:0] r_share;
    logic [DataW-1:0] n_share;

    always_comb begin
        n_share = r_share;
        if (i_clear) begin
            n_share = '0;
        end else if (i_round.fill && (i_rank < i_round.active)) begin
            n_share = r_share + i_round.each[DataW-1:0]
                + {{(DataW-1){1'b0}}, (i_rank < i_round.extra)};
        end
    end

    always_ff @(posedge i_clk) begin
        r_share <= n_share;
    end

    assign o_share = r_share;
endmodule
`default_nettype wire

// ===== hw/rtl/wfps_div.sv =====
// Divider of a fill total by an active count of one to four: shifts or a reciprocal multiply
`default_nettype none
module wfps_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [wfps_pkg::DataW-1:0] i_num,
    input  wire logic [wfps_pkg::CntW-1:0]  i_den,
    output logic                   o_done,
    output logic [wfps_pkg::DataW:0]        o_quo,
    output logic [wfps_pkg::CntW-1:0]       o_rem
);
    import wfps_pkg::*;
    logic [DataW-1:0]   r_quo;
    logic [CntW-1:0]    r_rem;
    logic               r_done;
    logic [2*DataW-1:0] w_prod;
    logic [DataW-1:0]   w_q3;
    logic [DataW-1:0]   w_r3;
    logic [DataW-1:0]   w_quo;
    logic [CntW-1:0]    w_rem;

    assign w_prod = {{DataW{1'b0}}, i_num} * {{DataW{1'b0}}, DivThreeRecip};
    assign w_q3   = {1'b0, w_prod[2*DataW-1:DataW+1]};
    assign w_r3   = i_num - {w_q3[DataW-2:0], 1'b0} - w_q3;

    always_comb begin
        case (i_den)
            CntW'(1): begin
                w_quo = i_num;
                w_rem = '0;
            end
            CntW'(2): begin
                w_quo = {1'b0, i_num[DataW-1:1]};
                w_rem = {{(CntW-1){1'b0}}, i_num[0]};
            end
            CntW'(3): begin
                w_quo = w_q3;
                w_rem = w_r3[CntW-1:0];
            end
            CntW'(4): begin
                w_quo = {2'b00, i_num[DataW-1:2]};
                w_rem = {{(CntW-2){1'b0}}, i_num[1:0]};
            end
            default: begin
                w_quo = i_num;
                w_rem = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
            if (i_start) begin
                r_quo <= w_quo;
                r_rem <= w_rem;
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = {1'b0, r_quo};
    assign o_rem  = r_rem;
endmodule
`default_nettype wire

// ===== hw/rtl/waterfill_path_splitter_unit.sv =====
// Top level of the water-filling path splitter
// Sequence from accept to result, worst case with K = paths in use: one rank step,
// per fill round a limit step, a divide and an add, then a done step.
// Throughput: one request at a time; the next is taken the cycle after the result is
// loaded into the output register, and a result still waiting there holds the done cycle.
// Reset: synchronous active-low; path_count returns to 4, control goes idle.
`default_nettype none
module waterfill_path_splitter_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_amount,
    input  wire logic signed [31:0] i_balance_0,
    input  wire logic signed [31:0] i_balance_1,
    input  wire logic signed [31:0] i_balance_2,
    input  wire logic signed [31:0] i_balance_3,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_share_0,
    output logic [31:0]      o_share_1,
    output logic [31:0]      o_share_2,
    output logic [31:0]      o_share_3,
    output logic [31:0]      o_unsent
);
    import wfps_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_RANK  = 6'b000010,
        S_LIMIT = 6'b000100,
        S_DIV   = 6'b001000,
        S_ADD   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state;
    logic [2:0] r_pcount;
    logic [CntW-1:0] r_n;
    t_bal r_bal [NumPaths];
    logic [CntW-1:0] r_rank [NumPaths];
    logic [IdxW-1:0] r_ord [NumPaths];
    logic [CntW-1:0] r_k;
    logic [DataW-1:0] r_rem;
    logic [DataW:0] r_total;
    logic r_clear;
    t_round w_round;
    logic w_fill_go;
    logic w_div_start;
    logic w_div_done;
    logic [DataW:0] w_quo;
    logic [CntW-1:0] w_drem;
    logic [DataW-1:0] w_share [NumPaths];
    logic [DataW-1:0] r_oshare [NumPaths];
    logic [DataW-1:0] r_ounsent;
    logic r_ovalid;
    t_bal w_in [NumPaths];
    logic [CntW-1:0] w_rank [NumPaths];
    t_bal w_top, w_next;
    logic [DataW:0] w_gap;
    logic [DataW+CntW:0] w_limit;

    assign pready = 1'b1;
    assign prdata = (paddr[3:2] == AddrPathCount) ? {29'd0, r_pcount} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcount <= PathCountReset;
        end else if (psel && penable && pwrite && paddr[3:2] == AddrPathCount) begin
            r_pcount <= pwdata[2:0];
        end
    end

    assign w_in[0] = i_balance_0;
    assign w_in[1] = i_balance_1;
    assign w_in[2] = i_balance_2;
    assign w_in[3] = i_balance_3;

    // rank of lane i: count of in-use lanes ranking ahead of it
    always_comb begin
        for (int i = 0; i < NumPaths; i++) begin
            w_rank[i] = '0;
            for (int j = 0; j < NumPaths; j++) begin
                if (j != i && CntW'(j) < r_n &&
                    (r_bal[j] > r_bal[i] || (r_bal[j] == r_bal[i] && j > i))) begin
                    w_rank[i] = w_rank[i] + 1'b1;
                end
            end
        end
    end

    always_comb begin
        w_top  = r_bal[r_ord[r_k[IdxW-1:0]]];
        w_next = '0;
        if (r_k + 1'b1 < r_n) begin
            w_next = r_bal[r_ord[IdxW'(r_k + 1'b1)]];
        end
        if (w_next < 0) begin
            w_next = '0;
        end
        w_gap   = {w_top[DataW-1], w_top} - {w_next[DataW-1], w_next};
        w_limit = (DataW+CntW+1)'(w_gap) * (DataW+CntW+1)'(r_k + 1'b1);
    end

    assign w_fill_go   = (r_state == S_LIMIT) && (w_top > 0) && (r_rem != '0);
    assign w_div_start = (r_state == S_DIV) && !w_div_done;
    assign w_round.fill   = (r_state == S_ADD);
    assign w_round.active = r_k + 1'b1;
    assign w_round.each   = w_quo;
    assign w_round.extra  = w_drem;

    wfps_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_num(r_total[DataW-1:0]), .i_den(r_k + 1'b1),
        .o_done(w_div_done), .o_quo(w_quo), .o_rem(w_drem)
    );

    for (genvar g = 0; g < NumPaths; g++) begin : g_lane
        wfps_lane u_lane (
            .i_clk(i_clk), .i_clear(r_clear), .i_round(w_round),
            .i_rank(r_rank[g]), .o_share(w_share[g])
        );
    end

    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_clear  <= 1'b0;
        end else begin
            r_clear <= 1'b0;
            if (r_ovalid && i_ready && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        for (int i = 0; i < NumPaths; i++) begin
                            r_bal[i] <= w_in[i];
                        end
                        r_rem   <= i_amount;
                        r_n     <= (r_pcount > 3'(NumPaths)) ? CntW'(NumPaths)
                                                            : CntW'(r_pcount);
                        r_clear <= 1'b1;
                        r_k     <= '0;
                        r_state <= S_RANK;
                    end
                end
                S_RANK: begin
                    for (int i = 0; i < NumPaths; i++) begin
                        r_rank[i] <= (CntW'(i) < r_n) ? w_rank[i] : CntW'(NumPaths);
                        if (CntW'(i) < r_n) begin
                            r_ord[w_rank[i][IdxW-1:0]] <= IdxW'(i);
                        end
                    end
                    r_state <= (r_n == '0) ? S_DONE : S_LIMIT;
                end
                S_LIMIT: begin
                    if (w_fill_go) begin
                        r_total <= ({1'b0, r_rem} < w_limit)
                            ? {1'b0, r_rem} : w_limit[DataW:0];
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_rem <= r_rem - r_total[DataW-1:0];
                    r_k   <= r_k + 1'b1;
                    r_state <= (r_k + 1'b1 < r_n) ? S_LIMIT : S_DONE;
                end
                S_DONE: begin
                    if (!r_ovalid || i_ready) begin
                        for (int i = 0; i < NumPaths; i++) begin
                            r_oshare[i] <= w_share[i];
                        end
                        r_ounsent <= r_rem;
                        r_ovalid  <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid   = r_ovalid;
    assign o_share_0 = r_oshare[0];
    assign o_share_1 = r_oshare[1];
    assign o_share_2 = r_oshare[2];
    assign o_share_3 = r_oshare[3];
    assign o_unsent  = r_ounsent;

`ifndef ASSERT_OFF
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_add_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD) |-> $past(w_div_done)) else $error("add without divide");
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD) |-> (r_total <= {1'b0, r_rem})) else $error("total exceeds rest");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_RANK)) else $error("accept lost");
`endif
endmodule
`default_nettype wire
